// ===== src/mldsa_bp_pkg.sv =====
// Package for the ML-DSA coefficient bit packer.
// Holds the queue word type, mode codes and the per-mode field decode.
// No dependencies.
package mldsa_bp_pkg;

   localparam int unsigned COEFF_W = 21;
   localparam int unsigned FIELD_W = 20;
   localparam int unsigned PEND_W  = 7;
   localparam int unsigned ACC_W   = 27;
   localparam int unsigned MODE_W  = 3;

   // Register byte addresses
   localparam logic [2:0] CSR_ADDR_PACK_MODE = 3'd0;

   typedef enum logic [MODE_W-1:0] {
      MODE_T1   = 3'd0,
      MODE_ETA2 = 3'd1,
      MODE_ETA4 = 3'd2,
      MODE_T0   = 3'd3,
      MODE_Z17  = 3'd4,
      MODE_Z19  = 3'd5
   } pack_mode_type;

   typedef struct packed {
      logic [4:0]         width;
      logic [FIELD_W-1:0] offset;
      logic [FIELD_W-1:0] max_val;
      logic [FIELD_W-1:0] mask;
      logic               negate;
   } mode_info_type;

   // One queue word: the bytes an item produces and how many of them go out
   typedef struct packed {
      logic [23:0] acc;
      logic [1:0]  nbytes;
      logic        err;
   } pack_word_type;

   function automatic mode_info_type mode_decode(input logic [MODE_W-1:0] mode);
      mode_info_type info;
      case (mode)
         MODE_ETA2: info = '{5'd3,  20'd2,       20'd4,       20'h00007, 1'b1};
         MODE_ETA4: info = '{5'd4,  20'd4,       20'd8,       20'h0000F, 1'b1};
         MODE_T0:   info = '{5'd13, 20'd4096,    20'h01FFF,   20'h01FFF, 1'b1};
         MODE_Z17:  info = '{5'd18, 20'h20000,   20'h3FFFF,   20'h3FFFF, 1'b1};
         MODE_Z19:  info = '{5'd20, 20'h80000,   20'hFFFFF,   20'hFFFFF, 1'b1};
         default:   info = '{5'd10, 20'd0,       20'h003FF,   20'h003FF, 1'b0};
      endcase
      return info;
   endfunction

endpackage

// ===== src/mldsa_bp_front.sv =====
// Front end of the bit packer: maps a coefficient to its field, merges it
// with the leftover bits and pushes the complete bytes as one queue word.
// Depends on mldsa_bp_pkg.
module mldsa_bp_front
   import mldsa_bp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [MODE_W-1:0]    pack_mode,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [COEFF_W-1:0]   coeff,
   input  logic                 poly_last,
   input  logic                 q_ready,
   output logic                 q_push,
   output pack_word_type        q_word
);

   mode_info_type           info;
   logic signed [22:0]      c_ext;
   logic signed [22:0]      t_val;
   logic                    bad;
   logic [FIELD_W-1:0]      field;
   logic [ACC_W-1:0]        acc;
   logic [4:0]              total;
   logic [1:0]              full;
   logic                    pad;
   logic [1:0]              nbytes;
   logic                    err_now;
   logic                    accept;

   logic [PEND_W-1:0]       pend_bits_ff,  pend_bits_in;
   logic [2:0]              pend_count_ff, pend_count_in;
   logic                    sticky_ff,     sticky_in;

   assign in_ready = q_ready;
   assign accept   = in_valid && q_ready;

   always_comb begin
      info  = mode_decode(pack_mode);
      c_ext = {{2{coeff[COEFF_W-1]}}, coeff};
      if (info.negate) begin
         t_val = $signed({3'b000, info.offset}) - c_ext;
      end else begin
         t_val = c_ext;
      end
      bad     = t_val[22] || (t_val > $signed({3'b000, info.max_val}));
      field   = t_val[FIELD_W-1:0] & info.mask;
      acc     = ({7'd0, field} << pend_count_ff) | {20'd0, pend_bits_ff};
      total   = {2'b00, pend_count_ff} + info.width;
      full    = total[4:3];
      // padded flush byte only if leftover bits remain and there is room
      pad     = poly_last && (total[2:0] != 3'd0) && (full != 2'd3);
      nbytes  = full + {1'b0, pad};
      err_now = sticky_ff || bad;
   end

   assign q_push        = accept && (nbytes != 2'd0);
   assign q_word.acc    = acc[23:0];
   assign q_word.nbytes = nbytes;
   assign q_word.err    = err_now;

   always_comb begin
      pend_bits_in  = pend_bits_ff;
      pend_count_in = pend_count_ff;
      sticky_in     = sticky_ff;
      if (accept) begin
         if (poly_last) begin
            pend_bits_in  = '0;
            pend_count_in = '0;
            sticky_in     = 1'b0;
         end else begin
            pend_bits_in  = PEND_W'(acc >> {full, 3'b000});
            pend_count_in = total[2:0];
            sticky_in     = err_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff  <= '0;
         pend_count_ff <= '0;
         sticky_ff     <= 1'b0;
      end else begin
         pend_bits_ff  <= pend_bits_in;
         pend_count_ff <= pend_count_in;
         sticky_ff     <= sticky_in;
      end
   end

endmodule

// ===== src/mldsa_bp_queue.sv =====
// Small word queue between the packer front end and the byte emitter.
// Depends on mldsa_bp_pkg.
module mldsa_bp_queue
   import mldsa_bp_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  pack_word_type  push_word,
   output logic           not_full,
   input  logic           pop,
   output logic           not_empty,
   output pack_word_type  head_word
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   pack_word_type      mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;

   assign not_full  = (count_ff != CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_word = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (not_full || pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");

endmodule

// ===== src/mldsa_bp_back.sv =====
// Byte emitter: walks the bytes of the queue head word into the output
// register, one byte a cycle while out_ready allows. Depends on mldsa_bp_pkg.
module mldsa_bp_back
   import mldsa_bp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   input  pack_word_type  q_word,
   output logic           q_pop,
   output logic           out_valid,
   input  logic           out_ready,
   output logic [7:0]     out_byte,
   output logic           run_last,
   output logic           range_error
);

   logic [1:0] idx_ff,   idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff,  byte_in;
   logic       last_ff,  last_in;
   logic       err_ff,   err_in;
   logic       load;
   logic       word_end;
   logic [7:0] sel_byte;

   assign load     = q_valid && (!valid_ff || out_ready);
   assign word_end = (idx_ff == (q_word.nbytes - 2'd1));
   assign q_pop    = load && word_end;

   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = q_word.acc[7:0];
         2'd1:    sel_byte = q_word.acc[15:8];
         2'd2:    sel_byte = q_word.acc[23:16];
         default: sel_byte = 8'd0;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      err_in   = err_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = sel_byte;
         last_in  = word_end;
         err_in   = q_word.err;
         idx_in   = word_end ? 2'd0 : idx_ff + 2'd1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign out_valid   = valid_ff;
   assign out_byte    = byte_ff;
   assign run_last    = last_ff;
   assign range_error = err_ff;

endmodule

// ===== src/ml_dsa_coefficient_bit_packer.sv =====
// ML-DSA coefficient bit packer, top level.
// Depends on mldsa_bp_pkg, mldsa_bp_front, mldsa_bp_queue, mldsa_bp_back.
//
// Usage:
//   req_*  : one coefficient a word. tdata[20:0] holds the signed coefficient,
//            tlast marks the final coefficient of a polynomial.
//   rsp_*  : one packed byte a word, LSB-first bit order. tlast marks the last
//            byte that an input word produced, tuser is the sticky range error
//            of the current polynomial.
//   csr_*  : APB-style port, register pack_mode at byte address 0.
//   A coefficient gives zero to three bytes. The front end takes one word a
//   cycle while the queue has room; the emitter sends one byte a cycle while
//   bytes wait and rsp_tready allows, so the front end can take new words
//   while the bytes of earlier ones still drain. The first byte of a word
//   passes the queue and then the output register before it is on rsp.
//   Reset clears the bit accumulator, the error flag, the queue and selects t1.
//   When rsp_tready is low the output byte holds, the queue fills and then
//   req_tready drops until bytes drain. Change pack_mode only while idle.
module ml_dsa_coefficient_bit_packer
   import mldsa_bp_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [20:0] coeff, [23:21] zero
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser,   // [0] range_error
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              q_ready;
   logic              q_push;
   pack_word_type     q_word;
   logic              q_valid;
   logic              q_pop;
   pack_word_type     q_head;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_ADDR_PACK_MODE) ? {29'd0, mode_ff} : 32'd0;

   always_comb begin
      mode_in = mode_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_ADDR_PACK_MODE)) begin
         mode_in = csr_pwdata[MODE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_T1;
      end else begin
         mode_ff <= mode_in;
      end
   end

   mldsa_bp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .pack_mode (mode_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .coeff     (req_tdata[COEFF_W-1:0]),
      .poly_last (req_tlast),
      .q_ready   (q_ready),
      .q_push    (q_push),
      .q_word    (q_word)
   );

   mldsa_bp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_word),
      .not_full  (q_ready),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head_word (q_head)
   );

   mldsa_bp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_word      (q_head),
      .q_pop       (q_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_byte    (rsp_tdata),
      .run_last    (rsp_tlast),
      .range_error (rsp_tuser[0])
   );

endmodule
